@@ hw/rtl/rvvt_pkg.sv @@
`timescale 1ns / 1ps

package rvvt_pkg;

  // Request kinds carried on the slave-side tuser.
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_CHECK  = 2'd2;
  localparam logic [1:0] REQ_COUNT  = 2'd3;

  // Result status codes carried on the master-side tuser.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP_DEL  = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_LIST_FULL = 2'd3;

  // Field widths of one request and one result.
  localparam int REQ_W   = 2;
  localparam int ROW_W   = 16;
  localparam int STAMP_W = 64;
  localparam int TOTAL_W = 14;
  localparam int STS_W   = 2;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 80;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic exec;
    logic resolve;
    logic probe_rd;
    logic probe_upd;
    logic rows_rd;
    logic rows_cap;
    logic out_load;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic             clear_done;
    logic [REQ_W-1:0] req_type;
    logic             len_zero;
    logic             first_zero;
    logic             out_free;
  } sts_t;

endpackage

@@ hw/rtl/rvvt_ctrl.sv @@
`timescale 1ns / 1ps

module rvvt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          ready,
  input  rvvt_pkg::sts_t sts,
  output rvvt_pkg::cmd_t cmd
);
  import rvvt_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR     = 8'b0000_0001,
    S_IDLE      = 8'b0000_0010,
    S_EXEC      = 8'b0000_0100,
    S_RD_WAIT   = 8'b0000_1000,
    S_SEARCH    = 8'b0001_0000,
    S_PROBE     = 8'b0010_0000,
    S_ROWS_WAIT = 8'b0100_0000,
    S_FINISH    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing pass over the delete store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    ready      = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.req_type) inside
          REQ_DELETE, REQ_CHECK: state_next = S_RD_WAIT;
          REQ_COUNT:             state_next = S_SEARCH;
          default:               state_next = S_FINISH;
        endcase
      end
      S_RD_WAIT: begin
        cmd.resolve = 1'b1;
        state_next  = S_FINISH;
      end
      S_SEARCH: begin
        if (sts.len_zero) begin
          if (sts.first_zero) begin
            state_next = S_FINISH;
          end else begin
            cmd.rows_rd = 1'b1;
            state_next  = S_ROWS_WAIT;
          end
        end else begin
          cmd.probe_rd = 1'b1;
          state_next   = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe_upd = 1'b1;
        state_next    = S_SEARCH;
      end
      S_ROWS_WAIT: begin
        cmd.rows_cap = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

@@ hw/rtl/rvvt_datapath.sv @@
`timescale 1ns / 1ps

module rvvt_datapath #(
  parameter int ROWS     = 8192,
  parameter int VERSIONS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rvvt_pkg::cmd_t                  cmd,
  output rvvt_pkg::sts_t                  sts,
  input  logic [rvvt_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [rvvt_pkg::REQ_W-1:0]      s_tuser,
  input  logic                            m_tready,
  output logic                            m_tvalid,
  output logic [rvvt_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [rvvt_pkg::STS_W-1:0]      m_tuser
);
  import rvvt_pkg::*;

  localparam int ROW_AW = $clog2(ROWS);
  localparam int VAW    = $clog2(VERSIONS);
  localparam int VCW    = $clog2(VERSIONS + 1);

  // Request held for the duration of one item.
  logic [REQ_W-1:0]   req_q;
  logic [ROW_W-1:0]   row_q;
  logic [STAMP_W-1:0] ts_q;
  logic [TOTAL_W-1:0] total_q;

  // Stores.
  logic [STAMP_W-1:0] del_mem [ROWS];
  logic [STAMP_W-1:0] vs_mem  [VERSIONS];
  logic [TOTAL_W-1:0] vr_mem  [VERSIONS];
  logic [STAMP_W-1:0] del_rdata;
  logic [STAMP_W-1:0] vs_rdata;
  logic [TOTAL_W-1:0] vr_rdata;

  // Control state.
  logic [ROW_AW-1:0]  clr_addr;
  logic [VCW-1:0]     vcount;
  logic [STAMP_W-1:0] latest;

  // Search window.
  logic [VCW-1:0] first;
  logic [VCW-1:0] len;
  logic [VCW-1:0] half;
  logic [VCW-1:0] mid;
  logic [VCW-1:0] first_m1;

  // Result being built and the output register.
  logic [STS_W-1:0]   res_status;
  logic               res_deleted;
  logic [TOTAL_W-1:0] res_visible;
  logic               out_valid;
  logic [STS_W-1:0]   out_status;
  logic               out_deleted;
  logic [TOTAL_W-1:0] out_visible;
  logic [STAMP_W-1:0] out_last;

  logic              row_in_range;
  logic              list_full;
  logic              app_wr;
  logic              del_wr;
  logic [ROW_AW-1:0] row_addr;

  // Per-request decode.
  assign row_in_range = ({1'b0, row_q} < (ROW_W + 1)'(ROWS));
  assign list_full    = (vcount == VCW'(VERSIONS));
  assign row_addr     = row_q[ROW_AW-1:0];
  assign app_wr       = cmd.exec && (req_q == REQ_APPEND) && !list_full;
  assign del_wr       = cmd.resolve && (req_q == REQ_DELETE) && row_in_range &&
                        (del_rdata == '0);
  assign half         = len >> 1;
  assign mid          = first + half;
  assign first_m1     = first - VCW'(1);

  // Request capture on the accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= s_tuser;
      row_q   <= s_tdata[ROW_W-1:0];
      ts_q    <= s_tdata[ROW_W +: STAMP_W];
      total_q <= s_tdata[ROW_W + STAMP_W +: TOTAL_W];
    end
  end

  // Delete store: clearing pass after reset, then read-modify-write for deletes.
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      del_mem[clr_addr] <= '0;
    end else if (del_wr) begin
      del_mem[row_addr] <= ts_q;
    end
    if (cmd.exec) begin
      del_rdata <= del_mem[row_addr];
    end
  end

  // Version list: appended in order, read at the probe point or the hit entry.
  always_ff @(posedge clk) begin
    if (app_wr) begin
      vs_mem[vcount[VAW-1:0]] <= ts_q;
      vr_mem[vcount[VAW-1:0]] <= total_q;
    end
    if (cmd.probe_rd) begin
      vs_rdata <= vs_mem[mid[VAW-1:0]];
    end
    if (cmd.rows_rd) begin
      vr_rdata <= vr_mem[first_m1[VAW-1:0]];
    end
  end

  // Clear address, version count and latest change stamp.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      vcount   <= '0;
      latest   <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + ROW_AW'(1);
      end
      if (app_wr) begin
        vcount <= vcount + VCW'(1);
        latest <= ts_q;
      end
      if (del_wr) begin
        latest <= ts_q;
      end
    end
  end

  // Binary search window over the version list.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      first <= '0;
      len   <= vcount;
    end else if (cmd.probe_upd) begin
      if (ts_q < vs_rdata) begin
        len <= half;
      end else begin
        first <= mid + VCW'(1);
        len   <= len - half - VCW'(1);
      end
    end
  end

  // Result fields of the current item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status  <= ST_OK;
      res_deleted <= 1'b0;
      res_visible <= '0;
    end else begin
      if (cmd.exec) begin
        if (req_q == REQ_APPEND && list_full) begin
          res_status <= ST_LIST_FULL;
        end else if (req_q == REQ_DELETE && !row_in_range) begin
          res_status <= ST_RANGE;
        end
      end
      if (cmd.resolve && row_in_range) begin
        if (req_q == REQ_DELETE && del_rdata != '0) begin
          res_status <= ST_DUP_DEL;
        end
        if (req_q == REQ_CHECK) begin
          res_deleted <= (del_rdata != '0) && (del_rdata <= ts_q);
        end
      end
      if (cmd.rows_cap) begin
        res_visible <= vr_rdata;
      end
    end
  end

  // Output register: holds a finished result until the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status  <= res_status;
      out_deleted <= res_deleted;
      out_visible <= res_visible;
      out_last    <= latest;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {1'b0, out_last, out_visible, out_deleted};

  // Status towards the controller.
  assign sts.clear_done = (clr_addr == ROW_AW'(ROWS - 1));
  assign sts.req_type   = req_q;
  assign sts.len_zero   = (len == '0);
  assign sts.first_zero = (first == '0);
  assign sts.out_free   = !out_valid || m_tready;

endmodule

@@ hw/rtl/row_version_visibility_table.sv @@
// After acceptance an append executes and finishes; a delete or check executes, resolves
// from the delete-store read and finishes; a row-count query executes, runs P probes with
// P <= ceil(log2(version count + 1)) (at most 7 for 64), reads a version entry unless the
// search ends at index 0, and finishes. Each probe is one registered read of the stamp
// memory, then one 64-bit compare. Throughput: one request at a time; s_tready returns
// with m_tvalid. Reset (rst, synchronous) clears ROWS delete stamps, one a cycle.
`timescale 1ns / 1ps

module row_version_visibility_table #(
  parameter int ROWS     = 8192,
  parameter int VERSIONS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // row_index [15:0], timestamp [79:16], row_total [93:80], zero [95:94]
  input  logic [rvvt_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type [1:0]
  input  logic [rvvt_pkg::REQ_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // is_deleted [0], visible_rows [14:1], last_change [78:15], zero [79]
  output logic [rvvt_pkg::OUT_DATA_W-1:0] m_tdata,
  // status [1:0]
  output logic [rvvt_pkg::STS_W-1:0]      m_tuser
);
  import rvvt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer for clearing, the per-request steps and the search.
  rvvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .ready    (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stores, search window and output register.
  rvvt_datapath #(
    .ROWS     (ROWS),
    .VERSIONS (VERSIONS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ hw/rtl/rvvt_checker.sv @@
`timescale 1ns / 1ps

module rvvt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [rvvt_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [rvvt_pkg::REQ_W-1:0]      s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rvvt_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [rvvt_pkg::STS_W-1:0]      m_tuser
);
  import rvvt_pkg::*;

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // The clearing pass keeps the slave side closed right after reset.
  a_clear_closed: assert property (@(posedge clk)
    $past(rst) |-> !s_tready)
    else $error("request taken during the clearing pass");

  // One request at a time: no beat is taken in the cycle after an accepted one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in progress");

  // A row reported as deleted always comes with an ok status.
  a_deleted_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tuser == ST_OK)
    else $error("deleted flag with an error status");

endmodule

bind row_version_visibility_table rvvt_checker u_rvvt_checker (.*);

@@ tb/sv/row_version_visibility_table_tb.sv @@
`timescale 1ns / 1ps

module row_version_visibility_table_tb;
  import rvvt_pkg::*;

  localparam logic [63:0] STAMP_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // One result beat, split into its fields.
  typedef struct {
    logic [1:0]  status;
    logic        deleted;
    logic [13:0] rows;
    logic [63:0] stamp;
  } visibility_result_t;

  // Mirror of the table contents and the queue of results still owed by the block.
  class visibility_scoreboard;
    localparam int ROW_CAP = 8192;
    localparam int VER_CAP = 64;

    logic [63:0]        del_stamp [ROW_CAP];
    logic [63:0]        ver_stamp [VER_CAP];
    logic [13:0]        ver_rows [VER_CAP];
    int unsigned        n_versions;
    logic [63:0]        last_stamp;
    visibility_result_t owed [$];
    int                 errors;
    int                 n_kind [4];
    int                 n_status [4];
    int                 n_hits;

    function new();
      foreach (del_stamp[i]) del_stamp[i] = '0;
      foreach (ver_stamp[i]) ver_stamp[i] = '0;
      foreach (ver_rows[i]) ver_rows[i] = '0;
      n_versions = 0;
      last_stamp = '0;
      errors = 0;
      n_hits = 0;
      foreach (n_kind[i]) n_kind[i] = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    // Binary search for the last version whose stamp is at or below ts.
    function logic [13:0] rows_at(logic [63:0] ts);
      int unsigned lo, len, half, mid;
      lo = 0;
      len = n_versions;
      while (len > 0) begin
        half = len / 2;
        mid = lo + half;
        if (mid >= VER_CAP) break;
        if (ts < ver_stamp[mid]) begin
          len = half;
        end else begin
          lo = mid + 1;
          len = len - half - 1;
        end
      end
      if (lo == 0 || lo > VER_CAP) return '0;
      return ver_rows[lo - 1];
    endfunction

    // Apply one accepted request beat and queue the result it must give.
    function void note_request(logic [1:0] kind, logic [15:0] row, logic [63:0] ts,
                               logic [13:0] total);
      visibility_result_t r;
      r.status = ST_OK;
      r.deleted = 1'b0;
      r.rows = '0;
      case (kind)
        REQ_APPEND: begin
          if (n_versions >= VER_CAP) begin
            r.status = ST_LIST_FULL;
          end else begin
            ver_stamp[n_versions] = ts;
            ver_rows[n_versions] = total;
            n_versions++;
            last_stamp = ts;
          end
        end
        REQ_DELETE: begin
          if (row >= ROW_CAP) begin
            r.status = ST_RANGE;
          end else if (del_stamp[row] != 0) begin
            r.status = ST_DUP_DEL;
          end else begin
            del_stamp[row] = ts;
            last_stamp = ts;
          end
        end
        REQ_CHECK: begin
          if (row < ROW_CAP)
            r.deleted = (del_stamp[row] != 0) && (del_stamp[row] <= ts);
          if (r.deleted) n_hits++;
        end
        default: begin
          r.rows = rows_at(ts);
        end
      endcase
      r.stamp = last_stamp;
      n_kind[kind]++;
      n_status[r.status]++;
      owed = {owed, r};
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    endfunction

    // Compare one accepted result beat with the oldest owed result.
    function void check_result(logic [1:0] sts, logic [79:0] data);
      visibility_result_t r;
      if (owed.size() == 0) begin
        $display("%0t ns: result beat with none expected, actual status %h data %h",
                 $time, sts, data);
        errors++;
        return;
      end
      r = owed.pop_front();
      if (sts !== r.status) report("status", r.status, sts);
      if (data[0] !== r.deleted) report("is_deleted", r.deleted, data[0]);
      if (data[14:1] !== r.rows) report("visible_rows", r.rows, data[14:1]);
      if (data[78:15] !== r.stamp) report("last_change", r.stamp, data[78:15]);
      if (data[79] !== 1'b0) report("tdata padding", 0, data[79]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // row_index [15:0], timestamp [79:16], row_total [93:80], zero [95:94]
  logic [95:0] s_tdata = '0;
  // req_type [1:0]
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // is_deleted [0], visible_rows [14:1], last_change [78:15], zero [79]
  logic [79:0] m_tdata;
  // status [1:0]
  logic [1:0]  m_tuser;

  visibility_scoreboard sb;
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;
  logic [63:0] append_stamp;

  row_version_visibility_table uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("row_version_visibility_table regression: fail");
    $finish;
  end

  // Offer one request beat after a random gap and wait for it to be taken.
  task automatic send_req(input logic [1:0] kind, input logic [15:0] row,
                          input logic [63:0] ts, input logic [13:0] total);
    int gap;
    if ($urandom_range(0, 63) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {2'b00, total, ts, row};
    do @(posedge clk); while (!s_tready);
    sb.note_request(kind, row, ts, total);
  endtask

  // Master side: stall at random, then take and check each result beat.
  task automatic take_results();
    int stall;
    forever begin
      if ($urandom_range(0, 63) == 0) take_burst = ~take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tuser, m_tdata);
    end
  endtask

  // Hand-picked requests: empty list, field extremes, ordering and the delete corner cases.
  task automatic run_directed();
    send_req(REQ_COUNT, 16'd0, 64'd0, 14'd0);
    send_req(REQ_COUNT, 16'd0, STAMP_MAX, 14'd0);
    send_req(REQ_CHECK, 16'd0, STAMP_MAX, 14'd0);
    send_req(REQ_APPEND, 16'hFFFF, 64'd0, 14'd0);
    send_req(REQ_COUNT, 16'd0, 64'd0, 14'd0);
    send_req(REQ_APPEND, 16'd0, 64'd100, 14'd8192);
    send_req(REQ_COUNT, 16'd0, 64'd99, 14'd0);
    send_req(REQ_COUNT, 16'd0, 64'd100, 14'd0);
    send_req(REQ_COUNT, 16'd0, STAMP_MAX, 14'd0);
    // Out-of-order append: stored as given.
    send_req(REQ_APPEND, 16'd0, 64'd50, 14'd5);
    send_req(REQ_COUNT, 16'd0, 64'd60, 14'd0);
    send_req(REQ_DELETE, 16'd0, 64'd200, 14'h3FFF);
    send_req(REQ_DELETE, 16'd0, 64'd300, 14'd0);
    send_req(REQ_CHECK, 16'd0, 64'd199, 14'd0);
    send_req(REQ_CHECK, 16'd0, 64'd200, 14'd0);
    send_req(REQ_DELETE, 16'd8191, STAMP_MAX, 14'd0);
    send_req(REQ_CHECK, 16'd8191, STAMP_MAX - 1, 14'd0);
    send_req(REQ_CHECK, 16'd8191, STAMP_MAX, 14'd0);
    send_req(REQ_DELETE, 16'd8192, 64'd5, 14'd0);
    send_req(REQ_DELETE, 16'hFFFF, 64'd5, 14'd0);
    send_req(REQ_CHECK, 16'hFFFF, STAMP_MAX, 14'd0);
    // A zero delete stamp leaves the row live, so a later delete is still accepted.
    send_req(REQ_DELETE, 16'd7, 64'd0, 14'd0);
    send_req(REQ_CHECK, 16'd7, STAMP_MAX, 14'd0);
    send_req(REQ_DELETE, 16'd7, 64'd9, 14'd0);
  endtask

  function automatic logic [15:0] pick_row();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 16'($urandom_range(0, 255));
    if (sel < 85) return 16'($urandom_range(0, 8191));
    if (sel < 95) return 16'($urandom_range(8192, 65535));
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'd8191;
      2: return 16'd8192;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [63:0] wide_rand();
    return {$urandom, $urandom};
  endfunction

  // Query stamp near a known stamp, so that both sides of each compare are hit.
  function automatic logic [63:0] near(logic [63:0] base);
    case ($urandom_range(0, 5))
      0: return base - 1;
      1: return base;
      2: return base + 1;
      3: return wide_rand();
      4: return 64'd0;
      default: return STAMP_MAX;
    endcase
  endfunction

  task automatic run_random(input int count);
    int          sel;
    logic [15:0] row;
    logic [63:0] ts;
    logic [63:0] base;
    logic [13:0] total;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      row = pick_row();
      total = 14'($urandom_range(0, 8192));
      if (sel < 10) begin
        // Appends mostly in timestamp order; the last slot takes the top stamp.
        append_stamp += 64'($urandom_range(1, 1 << 20));
        ts = append_stamp;
        if (sb.n_versions == 63) ts = STAMP_MAX;
        else if ($urandom_range(0, 15) == 0) ts = wide_rand();
        send_req(REQ_APPEND, row, ts, total);
      end else if (sel < 40) begin
        case ($urandom_range(0, 19))
          0: ts = 64'd0;
          1: ts = STAMP_MAX;
          2, 3, 4: ts = 64'($urandom_range(1, 1000));
          default: ts = wide_rand();
        endcase
        send_req(REQ_DELETE, row, ts, total);
      end else if (sel < 75) begin
        base = (row < 8192) ? sb.del_stamp[row] : wide_rand();
        send_req(REQ_CHECK, row, near(base), total);
      end else begin
        base = (sb.n_versions > 0) ?
               sb.ver_stamp[$urandom_range(0, sb.n_versions - 1)] : wide_rand();
        send_req(REQ_COUNT, row, near(base), total);
      end
    end
  endtask

  initial begin
    sb = new();
    append_stamp = 64'd1000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    fork
      take_results();
    join_none
    run_directed();
    run_random(1800);
    s_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Run covered %0d appends, %0d deletes, %0d checks and %0d row-count queries.",
             sb.n_kind[REQ_APPEND], sb.n_kind[REQ_DELETE], sb.n_kind[REQ_CHECK],
             sb.n_kind[REQ_COUNT]);
    $display("%0d ok, %0d repeat deletes, %0d out of range, %0d list full, %0d hits.",
             sb.n_status[ST_OK], sb.n_status[ST_DUP_DEL], sb.n_status[ST_RANGE],
             sb.n_status[ST_LIST_FULL], sb.n_hits);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("row_version_visibility_table regression: pass");
    end else begin
      $display("row_version_visibility_table regression: fail");
    end
    $finish;
  end

endmodule
